[rtl/lgst_pkg.sv]
// lgst_pkg: widths, constants and state encoding for the light gate speed timer.
// No dependencies; used by lgst_div, light_gate_speed_timer and lgst_chk.
`timescale 1ns / 1ps
`default_nettype none
package lgst_pkg;

  localparam int SPACING_W = 14;
  localparam logic [SPACING_W-1:0] SPACING_RST = 14'd500;

  // cm/s in Q8 from hundredths of a cm per 1 us tick: 1e6 / 100 * 256
  localparam int SCALE_W = 22;
  localparam logic [SCALE_W-1:0] SCALE_Q8 = 22'd2560000;

  localparam int K_W     = SPACING_W + SCALE_W;
  localparam int SPEED_W = 35;
  localparam int IVL_W   = 32;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 104;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage
`default_nettype wire

[rtl/lgst_div.sv]
// lgst_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on lgst_pkg for the dividend width.
`timescale 1ns / 1ps
`default_nettype none
module lgst_div #(
  parameter int DIVISOR_W = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lgst_pkg::K_W-1:0]  dividend_i,
  input  wire logic [DIVISOR_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [lgst_pkg::K_W-1:0]       quotient_o
);

  localparam int NW = lgst_pkg::K_W;
  localparam int CW = $clog2(NW);

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q;
  logic [NW-1:0]        quo_q, quo_d;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic [DIVISOR_W:0]   shifted, diff;
  logic                 ge;

  // dividend bits shift out of the top of quo_q while quotient bits enter at the bottom
  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = ~diff[DIVISOR_W];
    rem_d   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[NW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/light_gate_speed_timer.sv]
// Light gate speed timer: one tick transaction per cycle while idle; a pass through
// gate three starts two serial divisions (K/t1, K/t2) on one shared divider.
// The result is presented once both divisions are done; no tick is accepted while they
// run, nor while the result waits in front of a full output register. Ticks that
// close no pass are taken every cycle.
// Reset (async, active low): gates read as high, all arming and counts cleared, spacing 500.
`timescale 1ns / 1ps
`default_nettype none
module light_gate_speed_timer #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lgst_pkg::SPACING_W-1:0]  cfg_wdata_i,    // gate_spacing
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [0] gate_one_level, [1] gate_two_level, [2] gate_three_level, [7:3] zero
  input  wire logic [lgst_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [34:0] speed_q8, [66:35] first_interval, [98:67] second_interval, [103:99] zero
  output logic [lgst_pkg::M_TDATA_W-1:0]       m_axis_tdata_o,
  output logic                                 m_axis_tuser_o  // bad_interval
);

  localparam int KW = lgst_pkg::K_W;
  localparam int XW = (COUNT_WIDTH > lgst_pkg::IVL_W) ? COUNT_WIDTH : lgst_pkg::IVL_W;

  logic [lgst_pkg::SPACING_W-1:0] spacing_q;
  lgst_pkg::state_e state_q, state_d;

  logic prev1_q, prev2_q;
  logic armed1_q, armed2_q, run1_q, run2_q;
  logic [COUNT_WIDTH-1:0] cnt1_q, cnt2_q, lat_q;

  logic armed1_d, armed2_d, run1_d, run2_d;
  logic [COUNT_WIDTH-1:0] cnt1_d, cnt2_d, lat_d;
  logic [COUNT_WIDTH-1:0] t1_pick;
  logic fall1, fall2, fire, tick;

  logic [COUNT_WIDTH-1:0] t1_q, t2_q;
  logic [KW-1:0]          k_q, q1_q, q2_q;
  logic                   start_q;

  logic                   div_done;
  logic [KW-1:0]          div_quo;
  logic [COUNT_WIDTH-1:0] div_dvs;

  logic                   m_valid_q;
  logic [lgst_pkg::SPEED_W-1:0] speed_q;
  logic [lgst_pkg::IVL_W-1:0]   ivl1_q, ivl2_q;
  logic                   bad_q;

  logic [KW:0]                  sum;
  logic [lgst_pkg::SPEED_W-1:0] speed_sat;
  logic [XW-1:0]                t1x, t2x;
  logic [lgst_pkg::IVL_W-1:0]   ivl1_sat, ivl2_sat;
  logic                         out_free;

  assign s_axis_tready_o = (state_q == lgst_pkg::ST_IDLE);
  assign tick            = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  // per-tick gate sequence, in the order arm / hand over / close / count
  always_comb begin
    fall1    = prev1_q & ~s_axis_tdata_i[0];
    fall2    = prev2_q & ~s_axis_tdata_i[1];
    armed1_d = armed1_q | fall1;
    run1_d   = run1_q | fall1;
    armed2_d = armed2_q;
    run2_d   = run2_q;
    lat_d    = lat_q;
    cnt1_d   = cnt1_q;
    cnt2_d   = cnt2_q;
    if (fall2 && armed1_d) begin
      armed2_d = 1'b1;
      lat_d    = cnt1_q;
      run1_d   = 1'b0;
      run2_d   = 1'b1;
    end
    // first interval of a closing pass, taken before the clear
    t1_pick = lat_d;
    fire = ~s_axis_tdata_i[2] & armed2_d;
    if (fire) begin
      armed1_d = 1'b0;
      armed2_d = 1'b0;
      run1_d   = 1'b0;
      run2_d   = 1'b0;
      lat_d    = '0;
      cnt1_d   = '0;
      cnt2_d   = '0;
    end
    if (run1_d && cnt1_d != '1) cnt1_d = cnt1_d + 1'b1;
    if (run2_d && cnt2_d != '1) cnt2_d = cnt2_d + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= lgst_pkg::SPACING_RST;
      prev1_q   <= 1'b1;
      prev2_q   <= 1'b1;
      armed1_q  <= 1'b0;
      armed2_q  <= 1'b0;
      run1_q    <= 1'b0;
      run2_q    <= 1'b0;
      cnt1_q    <= '0;
      cnt2_q    <= '0;
      lat_q     <= '0;
    end else begin
      if (cfg_we_i) spacing_q <= cfg_wdata_i;
      if (tick) begin
        prev1_q  <= s_axis_tdata_i[0];
        prev2_q  <= s_axis_tdata_i[1];
        armed1_q <= armed1_d;
        armed2_q <= armed2_d;
        run1_q   <= run1_d;
        run2_q   <= run2_d;
        cnt1_q   <= cnt1_d;
        cnt2_q   <= cnt2_d;
        lat_q    <= lat_d;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgst_pkg::ST_IDLE: if (tick && fire) state_d = lgst_pkg::ST_DIV1;
      lgst_pkg::ST_DIV1: if (div_done) state_d = lgst_pkg::ST_DIV2;
      lgst_pkg::ST_DIV2: if (div_done) state_d = lgst_pkg::ST_DONE;
      lgst_pkg::ST_DONE: if (out_free) state_d = lgst_pkg::ST_IDLE;
      default:           state_d = lgst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lgst_pkg::ST_IDLE;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (tick & fire) | ((state_q == lgst_pkg::ST_DIV1) & div_done);
      if (state_q == lgst_pkg::ST_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready_i)                     m_valid_q <= 1'b0;
    end
  end

  // operands of the closing pass, and the two quotients as each division finishes
  always_ff @(posedge clk_i) begin
    if (tick && fire) begin
      t1_q <= t1_pick;
      t2_q <= cnt2_q;
      k_q  <= KW'(spacing_q) * KW'(lgst_pkg::SCALE_Q8);
    end
    if (state_q == lgst_pkg::ST_DIV1 && div_done) q1_q <= div_quo;
    if (state_q == lgst_pkg::ST_DIV2 && div_done) q2_q <= div_quo;
  end

  assign div_dvs = (state_q == lgst_pkg::ST_DIV2) ? t2_q : t1_q;

  lgst_div #(
    .DIVISOR_W (COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (k_q),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    sum       = {1'b0, q1_q} + {1'b0, q2_q};
    speed_sat = (sum[KW:lgst_pkg::SPEED_W+1] != '0) ? '1 : sum[lgst_pkg::SPEED_W:1];
    t1x       = XW'(t1_q);
    t2x       = XW'(t2_q);
    ivl1_sat  = (t1x > XW'(32'hFFFF_FFFF)) ? '1 : t1x[lgst_pkg::IVL_W-1:0];
    ivl2_sat  = (t2x > XW'(32'hFFFF_FFFF)) ? '1 : t2x[lgst_pkg::IVL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lgst_pkg::ST_DONE && out_free) begin
      bad_q   <= (t1_q == '0) | (t2_q == '0);
      speed_q <= ((t1_q == '0) || (t2_q == '0)) ? '0 : speed_sat;
      ivl1_q  <= ivl1_sat;
      ivl2_q  <= ivl2_sat;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, ivl2_q, ivl1_q, speed_q};
  assign m_axis_tuser_o  = bad_q;

endmodule
`default_nettype wire

[rtl/lgst_chk.sv]
// lgst_chk: port-level checks on the light gate speed timer, bound to the top level.
// Depends on lgst_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none
module lgst_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [lgst_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input wire logic                            m_axis_tuser_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a flagged result carries zero speed
  a_bad_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[34:0] == 35'd0)
    else $error("bad interval with nonzero speed");

  // flag set exactly when an interval is zero
  a_bad_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o ==
      (m_axis_tdata_o[66:35] == 32'd0 || m_axis_tdata_o[98:67] == 32'd0))
    else $error("bad interval flag mismatch");

  // a new result only follows the division, during which ticks are held off
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared without a division pass");

endmodule

bind light_gate_speed_timer lgst_chk u_lgst_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire
